// File: sv/mgf_pkg.sv
// Shared constants, types and functions for the MGF1 SHA-256 mask stream.
`timescale 1ns / 1ps
`default_nettype none
package mgf_pkg;
    localparam int MaxKeyBytes = 128;
    localparam int QueueDepth = 4;

    localparam logic FuncKey  = 1'b0;
    localparam logic FuncData = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_value;
        logic       first;
    } t_word;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
                6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
                6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
                6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
                6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
                6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
                6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
                6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
                6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
                6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
                6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
                default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction
endpackage
`default_nettype wire

// File: sv/mgf_queue.sv
// Word queue between the front and the back of the mask stream.
`timescale 1ns / 1ps
`default_nettype none
module mgf_queue
    import mgf_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_word i_word,
    output logic  o_valid,
    input  wire   i_ready,
    output t_word o_word
);
    localparam int AW = $clog2(DEPTH);
    t_word r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

// File: sv/mgf_engine.sv
// Back end: key store, SHA-256 round engine and mask XOR.
`timescale 1ns / 1ps
`default_nettype none
module mgf_engine
    import mgf_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MaxKeyBytes
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  t_word      i_word,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_masked_byte
);
    localparam int KA = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int LW = $clog2(MAX_KEY_BYTES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [7:0] r_key [MAX_KEY_BYTES];
    logic [2:0] r_state;
    logic [LW-1:0] r_klen;
    logic [31:0] r_ctr;
    logic [255:0] r_mask;
    logic [5:0] r_ptr;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0] r_t;
    logic [1:0] r_bsel;
    logic [5:0] r_lbyte;
    logic [15:0] r_base;
    logic [15:0] r_nblk;
    logic [15:0] r_blk;
    logic [7:0] r_kbyte;
    logic [7:0] r_data;
    logic r_ov;
    logic [7:0] r_out;

    logic [15:0] mlen, pos;
    logic [63:0] bits;
    logic [7:0] pbyte;
    logic [15:0] plen;
    logic [31:0] s0, s1, wn, wt, t1, t2, e, a;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_masked_byte = r_out;

    assign mlen = 16'(r_klen) + 16'd4;
    assign plen = ((mlen + 16'd8) >> 6) * 16'd64 + 16'd64;
    assign bits = {45'd0, mlen, 3'd0};
    assign pos  = r_base + {10'd0, r_lbyte};

    always_comb begin
        pbyte = 8'h00;
        if (pos < 16'(r_klen)) begin
            pbyte = r_kbyte;
        end else if (pos < mlen) begin
            case (2'(pos - 16'(r_klen)))
                2'd0: pbyte = r_ctr[31:24];
                2'd1: pbyte = r_ctr[23:16];
                2'd2: pbyte = r_ctr[15:8];
                default: pbyte = r_ctr[7:0];
            endcase
        end else if (pos == mlen) begin
            pbyte = 8'h80;
        end else if (pos >= plen - 16'd8) begin
            pbyte = bits[8*(7 - 3'(pos - (plen - 16'd8)))+:8];
        end
    end

    assign s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
    assign s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
              ^ (r_w[14] >> 10);
    assign wn = r_w[0] + s0 + r_w[9] + s1;
    assign wt = r_w[0];
    assign e  = r_v[4];
    assign a  = r_v[0];
    assign t1 = r_v[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(r_t) + wt;
    assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        r_kbyte <= r_key[KA'(pos)];
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_klen <= '0;
            r_ctr <= '0;
            r_ptr <= 6'd32;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        if (i_word.func == FuncKey) begin
                            if (i_word.first || r_klen < LW'(MAX_KEY_BYTES)) begin
                                r_key[i_word.first ? '0 : KA'(r_klen)] <= i_word.byte_value;
                                r_klen <= i_word.first ? LW'(1) : r_klen + 1'b1;
                            end
                            if (i_word.first) begin
                                r_ctr <= '0;
                                r_ptr <= 6'd32;
                            end
                        end else begin
                            r_data <= i_word.byte_value;
                            if (r_ptr[5]) begin
                                for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
                                r_base <= '0;
                                r_blk <= '0;
                                r_nblk <= plen >> 6;
                                r_lbyte <= '0;
                                r_bsel <= '0;
                                r_state <= S_LOAD;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                    end
                end
                S_LOAD: begin
                    // each byte: wait for the registered key store read, then shift it into the schedule
                    if (r_bsel == 2'd0) begin
                        r_bsel <= 2'd1;
                    end else begin
                        r_w[r_lbyte[5:2]] <= {r_w[r_lbyte[5:2]][23:0], pbyte};
                        r_bsel <= 2'd0;
                        r_lbyte <= r_lbyte + 1'b1;
                        if (r_lbyte == 6'd63) begin
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            r_t <= '0;
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wn;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_t <= r_t + 1'b1;
                    if (r_t == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (r_blk + 16'd1 == r_nblk) begin
                        for (int i = 0; i < 8; i++) r_mask[255-32*i-:32] <= r_h[i] + r_v[i];
                        r_ctr <= r_ctr + 1'b1;
                        r_ptr <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_blk <= r_blk + 1'b1;
                        r_base <= r_base + 16'd64;
                        r_lbyte <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_out <= r_data ^ r_mask[255-8*r_ptr[4:0]-:8];
                        r_ov <= 1'b1;
                        r_ptr <= r_ptr + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/mgf1_sha256_mask_stream.sv
// Top level of the MGF1 SHA-256 mask stream.
// Key words (func 0) load the key, first restarting it; data words (func 1) come out
// XORed with SHA-256(key || counter) bytes. A queue of four words decouples input from
// the engine. A key word is taken in the idle state; a data word from a held block is
// accepted, then XORed in the output state, where it waits while the previous result is
// not yet taken. A data word that needs a new block waits for the hash: per 64-byte block
// a byte-wise load (key bytes via the registered key store port), 64 rounds and an add
// step, then the XOR step.
`timescale 1ns / 1ps
`default_nettype none
module mgf1_sha256_mask_stream
    import mgf_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MaxKeyBytes
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire        i_func,
    input  wire [7:0]  i_byte_value,
    input  wire        i_first,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_masked_byte
);
    t_word in_word, q_word;
    logic q_valid, q_ready;

    assign in_word = '{func: i_func, byte_value: i_byte_value, first: i_first};

    mgf_queue #(.DEPTH(QueueDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_word(in_word),
        .o_valid(q_valid), .i_ready(q_ready), .o_word(q_word)
    );

    mgf_engine #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_word(q_word),
        .o_valid(o_valid), .i_ready(i_ready), .o_masked_byte(o_masked_byte)
    );
endmodule
`default_nettype wire
